// ----- sv/assert_macros.svh -----
// assertion macros shared by the mixer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ----- sv/mvsm_pkg.sv -----
// package with sizes, codes and shared types of the sample mixer
`timescale 1ns / 1ps
`default_nettype none

package mvsm_pkg;

    localparam int VOICE_COUNT = 4;
    localparam int SOUND_COUNT = 4;
    localparam int STORE_DEPTH = 65536;

    localparam int SAMPLE_W = 16;
    localparam int START_W  = 16;
    localparam int LEN_W    = 17;
    localparam int GAIN_W   = 9;
    localparam int MASK_W   = 4;

    localparam int SAW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int VIW   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int VCW   = $clog2(VOICE_COUNT + 1);
    localparam int SIW   = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;
    localparam int SUM_W = (SAW > LEN_W + 1) ? SAW : LEN_W + 1;
    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    // low bit of a register index selects start or length of a sound
    localparam logic CFG_SEL_START  = 1'b0;
    localparam logic CFG_SEL_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_PLAY = 2'd1,
        KIND_LOAD = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [START_W-1:0] base;
        logic [LEN_W-1:0]   length;
        logic [LEN_W-1:0]   position;
        logic [GAIN_W-1:0]  lgain;
        logic [GAIN_W-1:0]  rgain;
    } t_voice;

    typedef struct packed {
        logic                       vld;
        logic signed [SAMPLE_W-1:0] sample;
        logic [GAIN_W-1:0]          lgain;
        logic [GAIN_W-1:0]          rgain;
    } t_scale_req;

    typedef struct packed {
        logic                vld;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } t_scale_rsp;

endpackage

`default_nettype wire

// ----- sv/mvsm_ram.sv -----
// generic one-write one-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module mvsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/mvsm_scaler.sv -----
// gain unit: sample times left and right q8 gain, floor shift by 8, registered
`timescale 1ns / 1ps
`default_nettype none

module mvsm_scaler
    import mvsm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_scale_req i_req,
    output t_scale_rsp      o_rsp
);

    logic signed [PROD_W-1:0] w_prod_l;
    logic signed [PROD_W-1:0] w_prod_r;

    always_comb begin
        w_prod_l = PROD_W'(i_req.sample) * PROD_W'($signed({1'b0, i_req.lgain}));
        w_prod_r = PROD_W'(i_req.sample) * PROD_W'($signed({1'b0, i_req.rgain}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_rsp.vld <= 1'b0;
        end else begin
            o_rsp.vld <= i_req.vld;
        end
        // low 16 bits of the arithmetic shift by 8
        o_rsp.left  <= w_prod_l[SAMPLE_W+7:8];
        o_rsp.right <= w_prod_r[SAMPLE_W+7:8];
    end

endmodule

`default_nettype wire

// ----- sv/multi_voice_sample_mixer.sv -----
// top level of the multi-voice stereo sample playback mixer
//
// Four-voice stereo sample mixer. A load item (tuser 2) writes one signed
// sample word to the 64K-word sample store and a play item (tuser 1) restarts
// a voice on a configured sound with its left and right Q8 gains. A tick item
// (tuser 0) yields one frame on the master side: the voice memory is read for
// one voice per cycle, each playing voice then reads one sample word and
// passes the gain multipliers. A frame goes through the voice reads, three
// pipeline stages behind the last read, a step to see the pipeline empty and
// one to load the frame, and the input is taken again once it is loaded. A
// finished frame waits in the output register while the next items are taken;
// a second frame that finds the register still full holds the input until the
// master side takes the first. Sound starts and lengths are to be written on
// the config port at an idle time; the block itself leaves that to the user.
// The store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module multi_voice_sample_mixer
    import mvsm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // voice_index, sound_index, left_gain, right_gain, load_address, load_value
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // left_out, right_out, active_voices
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    t_state r_state, n_state;

    logic [START_W-1:0] r_cfg_start [SOUND_COUNT];
    logic [LEN_W-1:0]   r_cfg_len   [SOUND_COUNT];
    logic [VOICE_COUNT-1:0] r_active;

    logic [VCW-1:0] r_issue_cnt;
    logic           r_s1_vld;
    logic [VIW-1:0] r_s1_voice;
    logic              r_s2_vld;
    logic [GAIN_W-1:0] r_s2_lgain;
    logic [GAIN_W-1:0] r_s2_rgain;
    logic [SAMPLE_W-1:0] r_acc_l;
    logic [SAMPLE_W-1:0] r_acc_r;
    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;

    // input fields
    t_kind               w_kind;
    logic [1:0]          w_voice_idx;
    logic [1:0]          w_sound_idx;
    logic [GAIN_W-1:0]   w_lgain;
    logic [GAIN_W-1:0]   w_rgain;
    logic [15:0]         w_load_addr;
    logic [SAMPLE_W-1:0] w_load_val;

    logic w_in_acc, w_play, w_load, w_tick;
    logic w_issue, w_drained, w_out_load;
    logic w_s1_live, w_s1_end, w_s1_step;
    logic [SIW-1:0] w_sound_sel;
    logic [SIW-1:0] w_cfg_sound;
    logic [MASK_W-1:0] w_mask;
    logic [SUM_W-1:0]  w_addr_sum;

    logic           w_vm_we;
    logic [VIW-1:0] w_vm_waddr;
    t_voice         w_vm_wdata;
    t_voice         w_vm_rdata;
    logic [SAW-1:0]      w_sm_raddr;
    logic [SAMPLE_W-1:0] w_sm_rdata;

    t_scale_req w_req;
    t_scale_rsp w_rsp;

    assign w_kind      = t_kind'(s_axis_tuser);
    assign w_voice_idx = s_axis_tdata[1:0];
    assign w_sound_idx = s_axis_tdata[3:2];
    assign w_lgain     = s_axis_tdata[12:4];
    assign w_rgain     = s_axis_tdata[21:13];
    assign w_load_addr = s_axis_tdata[37:22];
    assign w_load_val  = s_axis_tdata[53:38];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_load        = w_in_acc && (w_kind == KIND_LOAD);
    assign w_tick        = w_in_acc && (w_kind == KIND_TICK);
    assign w_play        = w_in_acc && (w_kind == KIND_PLAY)
                           && (32'(w_voice_idx) < 32'(VOICE_COUNT))
                           && (32'(w_sound_idx) < 32'(SOUND_COUNT));
    assign w_sound_sel   = SIW'(w_sound_idx);
    assign w_cfg_sound   = SIW'(i_cfg_addr[CFG_IDX_W-1:1]);

    // voice pipeline: issue read, then check and fetch sample, then scale
    assign w_issue   = (r_state == ST_RUN) && (r_issue_cnt != VCW'(VOICE_COUNT));
    assign w_s1_live = r_s1_vld && r_active[r_s1_voice];
    assign w_s1_end  = w_s1_live && (w_vm_rdata.position >= w_vm_rdata.length);
    assign w_s1_step = w_s1_live && !w_s1_end;
    assign w_drained = (r_state == ST_RUN) && !w_issue && !r_s1_vld && !r_s2_vld
                       && !w_rsp.vld;
    assign w_addr_sum = SUM_W'(w_vm_rdata.base) + SUM_W'(w_vm_rdata.position);
    assign w_sm_raddr = w_addr_sum[SAW-1:0];

    always_comb begin
        w_vm_we    = 1'b0;
        w_vm_waddr = r_s1_voice;
        w_vm_wdata = w_vm_rdata;
        w_vm_wdata.position = w_vm_rdata.position + LEN_W'(1);
        if (w_play) begin
            w_vm_we             = 1'b1;
            w_vm_waddr          = VIW'(w_voice_idx);
            w_vm_wdata.base     = r_cfg_start[w_sound_sel];
            w_vm_wdata.length   = r_cfg_len[w_sound_sel];
            w_vm_wdata.position = '0;
            w_vm_wdata.lgain    = w_lgain;
            w_vm_wdata.rgain    = w_rgain;
        end else if (w_s1_step) begin
            w_vm_we = 1'b1;
        end
    end

    always_comb begin
        w_mask = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < VOICE_COUNT) begin
                w_mask[i] = r_active[i];
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_tick) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_drained) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SOUND_COUNT; s++) begin
                r_cfg_start[s] <= '0;
                r_cfg_len[s]   <= '0;
            end
        end else if (i_cfg_we && (32'(i_cfg_addr[CFG_IDX_W-1:1]) < 32'(SOUND_COUNT))) begin
            if (i_cfg_addr[0] == CFG_SEL_START) begin
                r_cfg_start[w_cfg_sound] <= i_cfg_data[START_W-1:0];
            end else if (i_cfg_addr[0] == CFG_SEL_LENGTH) begin
                r_cfg_len[w_cfg_sound] <= i_cfg_data[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_issue_cnt <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (w_play) begin
                r_active[VIW'(w_voice_idx)] <= 1'b1;
            end else if (w_s1_end) begin
                r_active[r_s1_voice] <= 1'b0;
            end
            if (w_tick) begin
                r_issue_cnt <= '0;
            end else if (w_issue) begin
                r_issue_cnt <= r_issue_cnt + VCW'(1);
            end
            r_s1_vld <= w_issue;
            r_s2_vld <= w_s1_step;
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_voice <= r_issue_cnt[VIW-1:0];
        r_s2_lgain <= w_vm_rdata.lgain;
        r_s2_rgain <= w_vm_rdata.rgain;
        if (w_tick) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (w_rsp.vld) begin
            r_acc_l <= r_acc_l + w_rsp.left;
            r_acc_r <= r_acc_r + w_rsp.right;
        end
        if (w_out_load) begin
            r_out_data <= {(OUT_DATA_W - 2 * SAMPLE_W - MASK_W)'(0), w_mask, r_acc_r, r_acc_l};
        end
    end

    mvsm_ram #(
        .WIDTH ($bits(t_voice)),
        .DEPTH (VOICE_COUNT)
    ) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (w_vm_we),
        .i_waddr (w_vm_waddr),
        .i_wdata (w_vm_wdata),
        .i_raddr (r_issue_cnt[VIW-1:0]),
        .o_rdata (w_vm_rdata)
    );

    mvsm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (SAW'(w_load_addr)),
        .i_wdata (w_load_val),
        .i_raddr (w_sm_raddr),
        .o_rdata (w_sm_rdata)
    );

    assign w_req.vld    = r_s2_vld;
    assign w_req.sample = w_sm_rdata;
    assign w_req.lgain  = r_s2_lgain;
    assign w_req.rgain  = r_s2_rgain;

    mvsm_scaler u_scaler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    `ASSERT_PROP(a_s2_follows_s1, i_clk, i_rst_n, r_s2_vld |-> $past(r_s1_vld))
    `ASSERT_NEVER(a_issue_bound, i_clk, i_rst_n, 32'(r_issue_cnt) > 32'(VOICE_COUNT))
    `ASSERT_PROP(a_load_drained, i_clk, i_rst_n, w_out_load |-> (!r_s1_vld && !r_s2_vld && !w_rsp.vld))
    `ASSERT_PROP(a_stop_in_run, i_clk, i_rst_n, (|($past(r_active) & ~r_active)) |-> $past(r_state == ST_RUN))

endmodule

`default_nettype wire
